>>> sv/scaled_reading_7seg_scanner_core_defines.svh
// assertion macros shared by the scanner checker
`ifndef SCALED_READING_7SEG_SCANNER_CORE_DEFINES_SVH
`define SCALED_READING_7SEG_SCANNER_CORE_DEFINES_SVH

// same-cycle implication, masked during reset
`define SRSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked during reset
`define SRSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// holds in the cycle after reset is applied
`define SRSS_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

>>> sv/srss_pkg.sv
// types, constants and helper functions for the scaled reading scanner
`timescale 1ns / 1ps

package srss_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int CFG_W      = 16;
  localparam int SCALED_W   = 16;
  localparam int SEG_W      = 8;
  localparam int SEL_W      = 4;
  localparam int DIGIT_W    = 4;
  localparam int BCD_W      = 20;
  localparam int DIGITS     = 4;
  localparam int POS_W      = 2;
  localparam int FRAC_BITS  = 10;
  localparam int PROD_W     = SAMPLE_W + CFG_W;
  localparam int HALF_W     = SCALED_W / 2;
  localparam int CFG_IDX_W  = 1;

  localparam int DIGIT_COUNT = 4;
  localparam int WRAP_LIMIT  = (DIGIT_COUNT < 1) ? 1 : ((DIGIT_COUNT > DIGITS) ? DIGITS : DIGIT_COUNT);

  localparam logic [CFG_W-1:0] SCALE_Q10_RST  = 16'd51096;
  localparam logic [CFG_W-1:0] HOLD_TICKS_RST = 16'd10;
  localparam logic [SEG_W-1:0] SEG_BLANK      = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE_Q10  = 1'b0,
    CFG_HOLD_TICKS = 1'b1
  } cfg_idx_t;

  typedef logic [DIGITS-1:0][DIGIT_W-1:0] digits_t;

  // eight shift-and-add-3 steps of the binary to bcd conversion
  function automatic logic [BCD_W-1:0] dabble8(input logic [BCD_W-1:0] bcd_in,
                                               input logic [HALF_W-1:0] bits);
    logic [BCD_W-1:0] bcd;
    bcd = bcd_in;
    for (int i = HALF_W - 1; i >= 0; i--) begin
      for (int j = 0; j < BCD_W / DIGIT_W; j++) begin
        if (bcd[j*DIGIT_W +: DIGIT_W] >= 4'd5) begin
          bcd[j*DIGIT_W +: DIGIT_W] = bcd[j*DIGIT_W +: DIGIT_W] + 4'd3;
        end
      end
      bcd = {bcd[BCD_W-2:0], bits[i]};
    end
    return bcd;
  endfunction

  // active-low pattern, point off
  function automatic logic [SEG_W-1:0] seg_encode(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] seg;
    case (d)
      4'd0:    seg = 8'hC0;
      4'd1:    seg = 8'hF9;
      4'd2:    seg = 8'hA4;
      4'd3:    seg = 8'hB0;
      4'd4:    seg = 8'h99;
      4'd5:    seg = 8'h92;
      4'd6:    seg = 8'h82;
      4'd7:    seg = 8'hF8;
      4'd8:    seg = 8'h80;
      4'd9:    seg = 8'h90;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

endpackage

>>> sv/srss_if.sv
// valid/ready channel interfaces for input, result and configuration
`timescale 1ns / 1ps

interface srss_in_if import srss_pkg::*;;
  logic                valid;
  logic                ready;
  logic                mode;
  logic [SAMPLE_W-1:0] adc_sample;

  modport source (output valid, output mode, output adc_sample, input ready);
  modport sink   (input valid, input mode, input adc_sample, output ready);
endinterface

interface srss_out_if import srss_pkg::*;;
  logic             valid;
  logic             ready;
  logic [SEG_W-1:0] segments;
  logic [SEL_W-1:0] digit_select;

  modport source (output valid, output segments, output digit_select, input ready);
  modport sink   (input valid, input segments, input digit_select, output ready);
endinterface

interface srss_cfg_if import srss_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] addr;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

>>> sv/srss_scan.sv
// scan position and hold counter, updated as each item is taken
`timescale 1ns / 1ps

module srss_scan import srss_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             tick,
  input  logic [CFG_W-1:0] hold_ticks,
  output logic [POS_W-1:0] pos_nxt
);

  logic [POS_W-1:0] pos_r;
  logic [CFG_W-1:0] hold_r;
  logic [CFG_W-1:0] hold_nxt;
  logic [CFG_W:0]   hold_inc;
  logic [POS_W:0]   pos_inc;

  always_comb begin
    hold_inc = {1'b0, hold_r} + 17'd1;
    pos_inc  = {1'b0, pos_r} + 3'd1;
    pos_nxt  = pos_r;
    hold_nxt = hold_r;
    if (!tick) begin
      pos_nxt  = '0;
      hold_nxt = '0;
    end else if (hold_inc >= {1'b0, hold_ticks}) begin
      hold_nxt = '0;
      if (pos_inc >= (POS_W + 1)'(WRAP_LIMIT)) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_inc[POS_W-1:0];
      end
    end else begin
      hold_nxt = hold_inc[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      hold_r <= '0;
    end else if (step) begin
      pos_r  <= pos_nxt;
      hold_r <= hold_nxt;
    end
  end

endmodule

>>> sv/scaled_reading_7seg_scanner_core.sv
// scaled reading seven-segment scanner: scale, bcd split, digit scan
//
//   channel  dir  payload                         transfer when
//   in_ch    in   mode, adc_sample                valid && ready
//   out_ch   out  segments, digit_select          valid && ready
//   cfg_ch   in   addr (0 scale_q10, 1 hold_ticks), data   valid (ready tied high)
//
// one item per cycle while the output is not stalled; five register stages from input transfer to result
// (input, scaled product, upper and lower bcd half, result)
// each stage refills as soon as the one after it moves, so bubbles close up
// under an output stall and input is taken until every stage is full
// synchronous active-low reset empties the pipe, clears digits and scan
// and reloads the default gain and hold
`timescale 1ns / 1ps

module scaled_reading_7seg_scanner_core import srss_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  srss_in_if.sink       in_ch,
  srss_out_if.source    out_ch,
  srss_cfg_if.sink      cfg_ch
);

  logic [CFG_W-1:0] scale_r;
  logic [CFG_W-1:0] hold_ticks_r;

  logic             in_xfer;
  logic [POS_W-1:0] pos_nxt;

  logic             v1_r, v2_r, v3_r, v4_r, vo_r;
  logic             ld1, ld2, ld3, ld4, ldo;

  logic                mode1_r, mode2_r, mode3_r, mode4_r;
  logic [POS_W-1:0]    pos1_r, pos2_r, pos3_r, pos4_r;
  logic [SAMPLE_W-1:0] sample1_r;
  logic [SCALED_W-1:0] scaled2_r;
  logic [BCD_W-1:0]    bcd3_r;
  logic [HALF_W-1:0]   low3_r;
  digits_t             digits4_r;

  logic [PROD_W-1:0] prod;
  logic [BCD_W-1:0]  bcd_hi;
  logic [BCD_W-1:0]  bcd_full;
  digits_t           digits_split;

  digits_t           store_r;
  digits_t           store_nxt;
  logic [SEG_W-1:0]  seg_r, seg_nxt;
  logic [SEL_W-1:0]  sel_r, sel_nxt;

  // configuration
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r      <= SCALE_Q10_RST;
      hold_ticks_r <= HOLD_TICKS_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.addr))
        CFG_SCALE_Q10:  scale_r      <= cfg_ch.data;
        CFG_HOLD_TICKS: hold_ticks_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // stage load enables
  assign ldo = !vo_r || out_ch.ready;
  assign ld4 = !v4_r || ldo;
  assign ld3 = !v3_r || ld4;
  assign ld2 = !v2_r || ld3;
  assign ld1 = !v1_r || ld2;

  assign in_ch.ready = ld1;
  assign in_xfer     = in_ch.valid && ld1;

  srss_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_xfer),
    .tick       (in_ch.mode),
    .hold_ticks (hold_ticks_r),
    .pos_nxt    (pos_nxt)
  );

  // datapath
  assign prod     = PROD_W'(sample1_r) * PROD_W'(scale_r);
  assign bcd_hi   = dabble8('0, scaled2_r[SCALED_W-1:HALF_W]);
  assign bcd_full = dabble8(bcd3_r, low3_r);

  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      digits_split[k] = bcd_full[(DIGITS - k)*DIGIT_W +: DIGIT_W];
    end
  end

  always_comb begin
    store_nxt = (mode4_r == 1'b0) ? digits4_r : store_r;
    seg_nxt   = seg_encode(store_nxt[pos4_r]);
    sel_nxt   = SEL_W'(1) << pos4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      vo_r    <= 1'b0;
      store_r <= '0;
    end else begin
      if (ld1) v1_r <= in_ch.valid;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
      if (ld4) v4_r <= v3_r;
      if (ldo) vo_r <= v4_r;
      if (v4_r && ldo) store_r <= store_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      mode1_r   <= in_ch.mode;
      sample1_r <= in_ch.adc_sample;
      pos1_r    <= pos_nxt;
    end
    if (ld2) begin
      mode2_r   <= mode1_r;
      pos2_r    <= pos1_r;
      scaled2_r <= prod[PROD_W-1:FRAC_BITS];
    end
    if (ld3) begin
      mode3_r <= mode2_r;
      pos3_r  <= pos2_r;
      bcd3_r  <= bcd_hi;
      low3_r  <= scaled2_r[HALF_W-1:0];
    end
    if (ld4) begin
      mode4_r   <= mode3_r;
      pos4_r    <= pos3_r;
      digits4_r <= digits_split;
    end
    if (ldo) begin
      seg_r <= seg_nxt;
      sel_r <= sel_nxt;
    end
  end

  assign out_ch.valid        = vo_r;
  assign out_ch.segments     = seg_r;
  assign out_ch.digit_select = sel_r;

endmodule

>>> sv/srss_checker.sv
// port-level checks for the scanner, bound to the top level
`timescale 1ns / 1ps
`include "scaled_reading_7seg_scanner_core_defines.svh"

module srss_checker import srss_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [SEG_W-1:0] segments,
  input logic [SEL_W-1:0] digit_select
);

  `SRSS_ASSERT_RST(a_empty_after_reset, !out_valid, "result valid right after reset")

  `SRSS_ASSERT_NEXT(a_result_held, out_valid && !out_ready,
    out_valid && $stable(segments) && $stable(digit_select), "stalled result changed")

  `SRSS_ASSERT_NOW(a_select_onehot, out_valid, $onehot(digit_select), "digit select not one-hot")

  `SRSS_ASSERT_NOW(a_point_off, out_valid, segments[SEG_W-1], "decimal point lit")

  `SRSS_ASSERT_NEXT(a_accept_after_stall, out_valid && !out_ready && !in_ready,
    out_valid, "result dropped while input blocked")

endmodule

bind scaled_reading_7seg_scanner_core srss_checker u_srss_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .segments     (out_ch.segments),
  .digit_select (out_ch.digit_select)
);
